[rtl/core/cbdm_pkg.sv]
// Shared types and constants for the cover block destination mapper.
// Holds the status codes, register map and fixed field widths.
// Has no dependencies.
`default_nettype none

package cbdm_pkg;

    // Widths of the fixed payload fields.
    localparam int COORD_W    = 16;
    localparam int STATUS_W   = 2;
    localparam int DEST_X_W   = 9;
    localparam int DEST_Y_W   = 8;
    localparam int DEST_WD_W  = 9;
    localparam int DEST_HT_W  = 8;
    localparam int SCALE_W    = 3;

    // Step counter of the divide sequence: quotient, remainder, scan setup.
    localparam int DIV_CNT_W  = 2;

    // Register bus.
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    typedef logic [STATUS_W-1:0]  t_status;
    typedef logic [REG_IDX_W-1:0] t_reg_idx;

    localparam t_status ST_VISIBLE = 2'd0;
    localparam t_status ST_OUTSIDE = 2'd1;
    localparam t_status ST_INVALID = 2'd2;

    localparam t_reg_idx REG_IMAGE_WIDTH  = 3'd0;
    localparam t_reg_idx REG_IMAGE_HEIGHT = 3'd1;
    localparam t_reg_idx REG_DECODE_SCALE = 3'd2;
    localparam t_reg_idx REG_CROP_LEFT    = 3'd3;
    localparam t_reg_idx REG_CROP_TOP     = 3'd4;
    localparam t_reg_idx REG_CROP_SPAN_X  = 3'd5;
    localparam t_reg_idx REG_CROP_SPAN_Y  = 3'd6;

endpackage

`default_nettype wire

[rtl/core/cover_block_destination_mapper_unit.sv]
// Top level of the cover block destination mapper: register bank, sequencer and
// the shared divide / scan datapath. Depends on cbdm_pkg.
// Uses APB-style configuration and valid/stall channels.
`default_nettype none

// Maps one inclusive source block onto the DISPLAY_WIDTH x DISPLAY_HEIGHT display
// using nearest-neighbor center sampling into the crop window. The block takes one
// request at a time. A request with a bad layout or a bad block goes straight to the
// done state. Otherwise each axis first divides the crop span by the display extent
// on one shared multiplier (quotient by a reciprocal constant, then remainder, then
// scan setup), then walks every display index of that axis once, one index per
// cycle, with an incremental quotient/remainder update. If no column samples inside
// the block, the row scan is skipped. The input stays stalled while a request is in
// progress. A finished result waits in the output register, and the next request is
// accepted meanwhile.
module cover_block_destination_mapper_unit #(
    parameter int DISPLAY_WIDTH    = 320,
    parameter int DISPLAY_HEIGHT   = 240,
    parameter int MAX_DECODE_SCALE = 3
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Configuration port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [cbdm_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [cbdm_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [cbdm_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                     pready,
    // Request channel
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic [cbdm_pkg::COORD_W-1:0]        i_block_left,
    input  wire logic [cbdm_pkg::COORD_W-1:0]        i_block_right,
    input  wire logic [cbdm_pkg::COORD_W-1:0]        i_block_top,
    input  wire logic [cbdm_pkg::COORD_W-1:0]        i_block_bottom,
    // Result channel
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic      [cbdm_pkg::STATUS_W-1:0]       o_status,
    output logic      [cbdm_pkg::DEST_X_W-1:0]       o_dest_x,
    output logic      [cbdm_pkg::DEST_Y_W-1:0]       o_dest_y,
    output logic      [cbdm_pkg::DEST_WD_W-1:0]      o_dest_width,
    output logic      [cbdm_pkg::DEST_HT_W-1:0]      o_dest_height
);

    localparam int CW     = cbdm_pkg::COORD_W;
    localparam int MAX_EXT = (DISPLAY_WIDTH > DISPLAY_HEIGHT) ? DISPLAY_WIDTH : DISPLAY_HEIGHT;
    localparam int EW     = $clog2(MAX_EXT + 1);
    localparam logic [EW-1:0] EXT_X = EW'(DISPLAY_WIDTH);
    localparam logic [EW-1:0] EXT_Y = EW'(DISPLAY_HEIGHT);
    localparam logic [cbdm_pkg::SCALE_W-1:0] MAX_SCALE = cbdm_pkg::SCALE_W'(MAX_DECODE_SCALE);

    // Reciprocal constants: span / E equals (span * ceil(2^K / E)) >> K when
    // K = CW + ceil(log2(E)), for every span of CW bits.
    localparam int KX = CW + $clog2(DISPLAY_WIDTH);
    localparam int KY = CW + $clog2(DISPLAY_HEIGHT);
    localparam int RW = CW + 2;
    localparam int PW = CW + RW;
    localparam logic [RW-1:0] RECIP_X =
        RW'(((64'd1 << KX) + 64'(DISPLAY_WIDTH) - 64'd1) / 64'(DISPLAY_WIDTH));
    localparam logic [RW-1:0] RECIP_Y =
        RW'(((64'd1 << KY) + 64'(DISPLAY_HEIGHT) - 64'd1) / 64'(DISPLAY_HEIGHT));

    localparam logic [cbdm_pkg::DIV_CNT_W-1:0] DIV_QUO = 2'd0;
    localparam logic [cbdm_pkg::DIV_CNT_W-1:0] DIV_REM = 2'd1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    // ------------------------------------------------------------------
    // Register bank
    // ------------------------------------------------------------------
    logic [CW-1:0]                  r_image_width, r_image_height;
    logic [cbdm_pkg::SCALE_W-1:0]   r_decode_scale;
    logic [CW-1:0]                  r_crop_left, r_crop_top;
    logic [CW-1:0]                  r_crop_span_x, r_crop_span_y;

    logic                           cfg_wr;
    cbdm_pkg::t_reg_idx             cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[cbdm_pkg::APB_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= '0;
            r_image_height <= '0;
            r_decode_scale <= '0;
            r_crop_left    <= '0;
            r_crop_top     <= '0;
            r_crop_span_x  <= '0;
            r_crop_span_y  <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                cbdm_pkg::REG_IMAGE_WIDTH:  r_image_width  <= pwdata[CW-1:0];
                cbdm_pkg::REG_IMAGE_HEIGHT: r_image_height <= pwdata[CW-1:0];
                cbdm_pkg::REG_DECODE_SCALE: r_decode_scale <= pwdata[cbdm_pkg::SCALE_W-1:0];
                cbdm_pkg::REG_CROP_LEFT:    r_crop_left    <= pwdata[CW-1:0];
                cbdm_pkg::REG_CROP_TOP:     r_crop_top     <= pwdata[CW-1:0];
                cbdm_pkg::REG_CROP_SPAN_X:  r_crop_span_x  <= pwdata[CW-1:0];
                cbdm_pkg::REG_CROP_SPAN_Y:  r_crop_span_y  <= pwdata[CW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            cbdm_pkg::REG_IMAGE_WIDTH:  prdata = 32'(r_image_width);
            cbdm_pkg::REG_IMAGE_HEIGHT: prdata = 32'(r_image_height);
            cbdm_pkg::REG_DECODE_SCALE: prdata = 32'(r_decode_scale);
            cbdm_pkg::REG_CROP_LEFT:    prdata = 32'(r_crop_left);
            cbdm_pkg::REG_CROP_TOP:     prdata = 32'(r_crop_top);
            cbdm_pkg::REG_CROP_SPAN_X:  prdata = 32'(r_crop_span_x);
            cbdm_pkg::REG_CROP_SPAN_Y:  prdata = 32'(r_crop_span_y);
            default:                    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Request check, done in the accept cycle
    // ------------------------------------------------------------------
    logic accept;
    logic layout_bad, block_bad;
    logic [CW:0] crop_end_x, crop_end_y;

    assign accept     = i_valid && !o_stall;
    assign crop_end_x = {1'b0, r_crop_left} + {1'b0, r_crop_span_x};
    assign crop_end_y = {1'b0, r_crop_top} + {1'b0, r_crop_span_y};

    assign layout_bad = (r_image_width == '0) || (r_image_height == '0) ||
                        (r_decode_scale > MAX_SCALE) ||
                        (r_crop_span_x == '0) || (crop_end_x > {1'b0, r_image_width}) ||
                        (r_crop_span_y == '0) || (crop_end_y > {1'b0, r_image_height});
    assign block_bad  = (i_block_left > i_block_right) || (i_block_top > i_block_bottom) ||
                        (i_block_right >= r_image_width) || (i_block_bottom >= r_image_height);

    // ------------------------------------------------------------------
    // Sequencer and shared datapath
    // ------------------------------------------------------------------
    logic [1:0]                      r_state;
    logic                            r_axis;      // 0 columns, 1 rows
    logic [cbdm_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic [CW-1:0]                   r_dq;        // quotient of span by extent
    logic [EW-1:0]                   r_rem;
    logic [CW:0]                     r_q;         // running sample offset
    logic [EW:0]                     r_r;         // running remainder, below twice the extent
    logic [CW-1:0]                   r_qinc;
    logic [EW:0]                     r_rinc;
    logic [EW-1:0]                   r_d;
    logic                            r_hit;
    logic [EW-1:0]                   r_first, r_last;
    logic [EW-1:0]                   r_fx, r_lx;
    logic [CW-1:0]                   r_bl, r_br, r_bt, r_bb;

    logic [cbdm_pkg::STATUS_W-1:0]   r_res_status;
    logic [cbdm_pkg::DEST_X_W-1:0]   r_res_x;
    logic [cbdm_pkg::DEST_Y_W-1:0]   r_res_y;
    logic [cbdm_pkg::DEST_WD_W-1:0]  r_res_w;
    logic [cbdm_pkg::DEST_HT_W-1:0]  r_res_h;

    logic                            r_out_valid;
    logic [cbdm_pkg::STATUS_W-1:0]   r_out_status;
    logic [cbdm_pkg::DEST_X_W-1:0]   r_out_x;
    logic [cbdm_pkg::DEST_Y_W-1:0]   r_out_y;
    logic [cbdm_pkg::DEST_WD_W-1:0]  r_out_w;
    logic [cbdm_pkg::DEST_HT_W-1:0]  r_out_h;

    logic [EW-1:0]  cur_ext;
    logic [CW-1:0]  cur_span, cur_start, cur_lo, cur_hi;
    logic [RW-1:0]  cur_recip;

    assign cur_ext   = r_axis ? EXT_Y : EXT_X;
    assign cur_span  = r_axis ? r_crop_span_y : r_crop_span_x;
    assign cur_start = r_axis ? r_crop_top : r_crop_left;
    assign cur_lo    = r_axis ? r_bt : r_bl;
    assign cur_hi    = r_axis ? r_bb : r_br;
    assign cur_recip = r_axis ? RECIP_Y : RECIP_X;

    // Shared multiplier: span times reciprocal for the quotient, then quotient
    // times extent for the remainder.
    logic [CW-1:0]  mul_a;
    logic [RW-1:0]  mul_b;
    logic [PW-1:0]  prod, prod_sh_x, prod_sh_y;
    logic [CW-1:0]  quo;
    logic [CW-1:0]  rem_full;

    assign mul_a     = (r_cnt == DIV_QUO) ? cur_span : r_dq;
    assign mul_b     = (r_cnt == DIV_QUO) ? cur_recip : {{(RW-EW){1'b0}}, cur_ext};
    assign prod      = PW'(mul_a) * PW'(mul_b);
    assign prod_sh_x = prod >> KX;
    assign prod_sh_y = prod >> KY;
    assign quo       = r_axis ? prod_sh_y[CW-1:0] : prod_sh_x[CW-1:0];
    assign rem_full  = cur_span - prod[CW-1:0];

    // With span = a*E + b, the first sample offset span/(2E) has quotient a/2 and
    // remainder b, plus E when a is odd. Each further index adds a and 2b.
    logic [EW:0]    r0_init;
    assign r0_init = r_dq[0] ? ({1'b0, cur_ext} + {1'b0, r_rem}) : {1'b0, r_rem};

    // Scan step.
    logic [CW-1:0]  span_m1, off;
    logic [CW:0]    sample;
    logic           hit;
    logic [EW+1:0]  r_sum;
    logic [EW+1:0]  two_ext;
    logic           wrap;
    logic [EW+1:0]  r_sum_red;
    logic [CW:0]    q_nx;
    logic           scan_last;
    logic           hit_fin;
    logic [EW-1:0]  first_fin, last_fin;

    assign span_m1   = cur_span - 1'b1;
    assign off       = (r_q >= {1'b0, cur_span}) ? span_m1 : r_q[CW-1:0];
    assign sample    = {1'b0, cur_start} + {1'b0, off};
    assign hit       = (sample >= {1'b0, cur_lo}) && (sample <= {1'b0, cur_hi});
    assign r_sum     = {1'b0, r_r} + {1'b0, r_rinc};
    assign two_ext   = {1'b0, cur_ext, 1'b0};
    assign wrap      = r_sum >= two_ext;
    assign r_sum_red = wrap ? (r_sum - two_ext) : r_sum;
    assign q_nx      = r_q + {1'b0, r_qinc} + (CW+1)'(wrap);
    assign scan_last = (r_d == cur_ext - 1'b1);
    assign hit_fin   = r_hit || hit;
    assign first_fin = r_hit ? r_first : r_d;
    assign last_fin  = hit ? r_d : r_last;

    // Result arithmetic, done at 32 bits and then cut to the field widths.
    logic [31:0] fx32, fy32, wx32, wy32;
    assign fx32 = 32'(r_fx);
    assign fy32 = 32'(first_fin);
    assign wx32 = 32'(r_lx) - 32'(r_fx) + 32'd1;
    assign wy32 = 32'(last_fin) - 32'(first_fin) + 32'd1;

    logic out_free;
    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= 1'b0;
            r_cnt       <= '0;
            r_d         <= '0;
            r_hit       <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_bl <= i_block_left;
                        r_br <= i_block_right;
                        r_bt <= i_block_top;
                        r_bb <= i_block_bottom;
                        if (layout_bad || block_bad) begin
                            r_res_status <= cbdm_pkg::ST_INVALID;
                            r_res_x      <= '0;
                            r_res_y      <= '0;
                            r_res_w      <= '0;
                            r_res_h      <= '0;
                            r_state      <= S_DONE;
                        end else begin
                            r_axis  <= 1'b0;
                            r_cnt   <= '0;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == DIV_QUO) begin
                        r_dq <= quo;
                    end else if (r_cnt == DIV_REM) begin
                        r_rem <= rem_full[EW-1:0];
                    end else begin
                        r_qinc  <= r_dq;
                        r_rinc  <= {r_rem, 1'b0};
                        r_q     <= {2'b00, r_dq[CW-1:1]};
                        r_r     <= r0_init;
                        r_d     <= '0;
                        r_hit   <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_q   <= q_nx;
                    r_r   <= r_sum_red[EW:0];
                    r_d   <= r_d + 1'b1;
                    r_hit <= hit_fin;
                    if (hit) begin
                        if (!r_hit) begin
                            r_first <= r_d;
                        end
                        r_last <= r_d;
                    end
                    if (scan_last) begin
                        if (!hit_fin) begin
                            r_res_status <= cbdm_pkg::ST_OUTSIDE;
                            r_res_x      <= '0;
                            r_res_y      <= '0;
                            r_res_w      <= '0;
                            r_res_h      <= '0;
                            r_state      <= S_DONE;
                        end else if (!r_axis) begin
                            r_fx    <= first_fin;
                            r_lx    <= last_fin;
                            r_axis  <= 1'b1;
                            r_cnt   <= '0;
                            r_state <= S_DIV;
                        end else begin
                            r_res_status <= cbdm_pkg::ST_VISIBLE;
                            r_res_x      <= fx32[cbdm_pkg::DEST_X_W-1:0];
                            r_res_y      <= fy32[cbdm_pkg::DEST_Y_W-1:0];
                            r_res_w      <= wx32[cbdm_pkg::DEST_WD_W-1:0];
                            r_res_h      <= wy32[cbdm_pkg::DEST_HT_W-1:0];
                            r_state      <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_status <= r_res_status;
                        r_out_x      <= r_res_x;
                        r_out_y      <= r_res_y;
                        r_out_w      <= r_res_w;
                        r_out_h      <= r_res_h;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_dest_x      = r_out_x;
    assign o_dest_y      = r_out_y;
    assign o_dest_width  = r_out_w;
    assign o_dest_height = r_out_h;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_stall_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_stall)
        else $error("input not stalled after a request transfer");

    a_div_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DIV) && (r_cnt != DIV_QUO) && (r_cnt != DIV_REM)) |->
        (r_rem < cur_ext))
        else $error("divider remainder out of range");

    a_scan_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_d < cur_ext) && (r_r < {1'b0, cur_ext, 1'b0}))
        else $error("scan index or remainder out of range");

    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != cbdm_pkg::ST_VISIBLE)) |->
        (o_dest_x == '0) && (o_dest_y == '0) && (o_dest_width == '0) &&
        (o_dest_height == '0))
        else $error("nonzero rectangle on a result that is not visible");

endmodule

`default_nettype wire

[test/tb_cover_block_destination_mapper_unit.sv]
`timescale 1ns / 100ps
// Self-checking testbench for cover_block_destination_mapper_unit: directed and random block
// requests under many crop layouts, each result checked against an in-bench coordinate mapper.
// Depends on cbdm_pkg and the unit RTL.

module tb_cover_block_destination_mapper_unit;

    localparam int COORD_W    = cbdm_pkg::COORD_W;
    localparam int SCALE_W    = cbdm_pkg::SCALE_W;
    localparam int STATUS_W   = cbdm_pkg::STATUS_W;
    localparam int DEST_X_W   = cbdm_pkg::DEST_X_W;
    localparam int DEST_Y_W   = cbdm_pkg::DEST_Y_W;
    localparam int DEST_WD_W  = cbdm_pkg::DEST_WD_W;
    localparam int DEST_HT_W  = cbdm_pkg::DEST_HT_W;
    localparam int APB_ADDR_W = cbdm_pkg::APB_ADDR_W;
    localparam int APB_DATA_W = cbdm_pkg::APB_DATA_W;

    localparam int DISP_W        = 320;
    localparam int DISP_H        = 240;
    localparam int MAX_SCALE     = 3;
    localparam int SCAN_LATENCY  = DISP_W + DISP_H + 8;
    localparam int LONG_HOLD     = 2500;
    localparam int RANDOM_ROUNDS = 12;
    localparam int ROUND_ITEMS   = 88;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [COORD_W-1:0] left, right, top, bottom;
    } t_block;

    typedef struct packed {
        cbdm_pkg::t_status      status;
        logic [DEST_X_W-1:0]    dest_x;
        logic [DEST_Y_W-1:0]    dest_y;
        logic [DEST_WD_W-1:0]   dest_width;
        logic [DEST_HT_W-1:0]   dest_height;
    } t_cover;

    typedef struct packed {
        logic [COORD_W-1:0] image_width, image_height;
        logic [SCALE_W-1:0] decode_scale;
        logic [COORD_W-1:0] crop_left, crop_top, crop_span_x, crop_span_y;
    } t_layout;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   i_valid = 1'b0;
    logic                   o_stall;
    logic [COORD_W-1:0]     i_block_left = '0;
    logic [COORD_W-1:0]     i_block_right = '0;
    logic [COORD_W-1:0]     i_block_top = '0;
    logic [COORD_W-1:0]     i_block_bottom = '0;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    logic [STATUS_W-1:0]    o_status;
    logic [DEST_X_W-1:0]    o_dest_x;
    logic [DEST_Y_W-1:0]    o_dest_y;
    logic [DEST_WD_W-1:0]   o_dest_width;
    logic [DEST_HT_W-1:0]   o_dest_height;

    t_layout    layout = '0;
    t_block     pending_blocks[$];
    t_cover     expected_covers[$];
    t_block     offered_block;
    t_cover     seen_cover, want_cover;
    int         items_issued = 0;
    int         results_checked = 0;
    int         fail_count = 0;
    int         visible_seen = 0;
    int         outside_seen = 0;
    int         invalid_seen = 0;
    int         layouts_applied = 0;
    bit         idle_on = 1'b1;
    int         holds_requested = 0;
    int         holds_served = 0;
    int         hold_left = 0;
    int         send_gap = 0;
    int         recv_gap = 0;

    cover_block_destination_mapper_unit #(
        .DISPLAY_WIDTH    (DISP_W),
        .DISPLAY_HEIGHT   (DISP_H),
        .MAX_DECODE_SCALE (MAX_SCALE)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_block_left   (i_block_left),
        .i_block_right  (i_block_right),
        .i_block_top    (i_block_top),
        .i_block_bottom (i_block_bottom),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_dest_x       (o_dest_x),
        .o_dest_y       (o_dest_y),
        .o_dest_width   (o_dest_width),
        .o_dest_height  (o_dest_height)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- mapper

    function automatic bit window_fits(input int unsigned start, span, limit);
        return span != 0 && start <= limit && span <= limit - start;
    endfunction

    // First and last display index on one axis whose sample lands in [lo, hi].
    function automatic bit scan_axis(input int unsigned extent, start, span, lo, hi,
                                     output int unsigned first, last);
        longint unsigned offset;
        int unsigned     s;
        bit              hit;
        hit = 1'b0;
        first = 0;
        last = 0;
        for (int unsigned d = 0; d < extent; d++) begin
            offset = ((64'(d) * 2 + 1) * span) / (64'(extent) * 2);
            if (offset >= span)
                offset = span - 1;
            s = (start + 32'(offset)) & 32'hFFFF;
            if (s >= lo && s <= hi) begin
                if (!hit)
                    first = d;
                last = d;
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic t_cover map_block_to_display(input t_block b, input t_layout l);
        t_cover      c;
        int unsigned fx, lx, fy, ly;
        bit          hit_x, hit_y;
        c = '0;
        c.status = cbdm_pkg::ST_INVALID;
        if (l.image_width == 0 || l.image_height == 0 || l.decode_scale > MAX_SCALE
            || !window_fits(l.crop_left, l.crop_span_x, l.image_width)
            || !window_fits(l.crop_top, l.crop_span_y, l.image_height))
            return c;
        if (b.left > b.right || b.top > b.bottom || b.right >= l.image_width
            || b.bottom >= l.image_height)
            return c;
        hit_x = scan_axis(DISP_W, l.crop_left, l.crop_span_x, b.left, b.right, fx, lx);
        hit_y = scan_axis(DISP_H, l.crop_top, l.crop_span_y, b.top, b.bottom, fy, ly);
        if (!hit_x || !hit_y) begin
            c.status = cbdm_pkg::ST_OUTSIDE;
            return c;
        end
        c.status      = cbdm_pkg::ST_VISIBLE;
        c.dest_x      = DEST_X_W'(fx);
        c.dest_y      = DEST_Y_W'(fy);
        c.dest_width  = DEST_WD_W'(lx - fx + 1);
        c.dest_height = DEST_HT_W'(ly - fy + 1);
        return c;
    endfunction

    // ------------------------------------------------------------- reporting

    function automatic string cover_text(input t_cover c);
        return $sformatf("status %0d x %0d y %0d w %0d h %0d",
                         c.status, c.dest_x, c.dest_y, c.dest_width, c.dest_height);
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    // -------------------------------------------------------------- stimulus

    function automatic int unsigned pick_extent();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom_range(1, 1000);
            4, 5, 6:    return $urandom_range(1, 65535);
            7:          return 65535;
            8:          return $urandom_range(1, 16);
            default:    return $urandom_range(DISP_W, 700);
        endcase
    endfunction

    function automatic t_layout random_layout(input bit broken);
        t_layout     l;
        int unsigned iw, ih, sx, sy;
        iw = pick_extent();
        ih = pick_extent();
        sx = $urandom_range(1, iw);
        sy = $urandom_range(1, ih);
        l.image_width  = COORD_W'(iw);
        l.image_height = COORD_W'(ih);
        l.decode_scale = SCALE_W'($urandom_range(0, MAX_SCALE));
        l.crop_left    = COORD_W'($urandom_range(0, iw - sx));
        l.crop_top     = COORD_W'($urandom_range(0, ih - sy));
        l.crop_span_x  = COORD_W'(sx);
        l.crop_span_y  = COORD_W'(sy);
        if (broken) begin
            case ($urandom_range(0, 4))
                0:       l.decode_scale = SCALE_W'($urandom_range(MAX_SCALE + 1, 7));
                1:       l.crop_span_x = '0;
                2:       l.crop_span_y = '0;
                // Window reaches one column past the right edge of the image.
                3:       l.crop_left = COORD_W'(iw - sx + 1);
                default: l.image_height = '0;
            endcase
        end
        return l;
    endfunction

    // Picks an inclusive range in [0, limit) for nonzero limit, mostly near the crop window.
    function automatic void pick_span(input int unsigned limit, start, span,
                                      output logic [COORD_W-1:0] lo, hi);
        int unsigned a, b, wlo, whi;
        if (limit == 0) begin
            a = $urandom_range(0, 65535);
            b = a + $urandom_range(0, 64);
        end else begin
            wlo = (start > 4) ? start - 4 : 0;
            whi = start + span + 3;
            if (whi > limit - 1)
                whi = limit - 1;
            if (wlo > whi)
                wlo = whi;
            case ($urandom_range(0, 3))
                0: begin
                    a = $urandom_range(wlo, whi);
                    b = a + $urandom_range(0, 7);
                end
                1: begin
                    a = $urandom_range(wlo, whi);
                    b = a + $urandom_range(0, span);
                end
                2: begin
                    a = $urandom_range(0, limit - 1);
                    b = $urandom_range(a, limit - 1);
                end
                default: begin
                    a = start;
                    b = start + span - 1;
                end
            endcase
            if (b > limit - 1)
                b = limit - 1;
            if (a > b)
                a = b;
        end
        lo = a[COORD_W-1:0];
        hi = b[COORD_W-1:0];
    endfunction

    function automatic void push_block(input logic [COORD_W-1:0] left, right, top, bottom);
        pending_blocks.push_back(t_block'{left, right, top, bottom});
        items_issued++;
    endfunction

    function automatic void queue_random_blocks(input int count);
        t_block b;
        int     roll;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                b = {16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
            end else begin
                pick_span(layout.image_width, layout.crop_left, layout.crop_span_x,
                          b.left, b.right);
                pick_span(layout.image_height, layout.crop_top, layout.crop_span_y,
                          b.top, b.bottom);
                if (roll < 11)
                    {b.left, b.right} = {b.right + 16'd1, b.left};
                else if (roll < 14)
                    {b.top, b.bottom} = {b.bottom + 16'd1, b.top};
                else if (roll < 16)
                    b.right = layout.image_width + 16'($urandom_range(0, 3));
                else if (roll < 18)
                    b.bottom = layout.image_height + 16'($urandom_range(0, 3));
            end
            push_block(b.left, b.right, b.top, b.bottom);
        end
    endfunction

    // ------------------------------------------------------ register access

    task automatic reg_write(input cbdm_pkg::t_reg_idx idx, input logic [COORD_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= APB_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_layout(input t_layout l);
        reg_write(cbdm_pkg::REG_IMAGE_WIDTH, l.image_width);
        reg_write(cbdm_pkg::REG_IMAGE_HEIGHT, l.image_height);
        reg_write(cbdm_pkg::REG_DECODE_SCALE, COORD_W'(l.decode_scale));
        reg_write(cbdm_pkg::REG_CROP_LEFT, l.crop_left);
        reg_write(cbdm_pkg::REG_CROP_TOP, l.crop_top);
        reg_write(cbdm_pkg::REG_CROP_SPAN_X, l.crop_span_x);
        reg_write(cbdm_pkg::REG_CROP_SPAN_Y, l.crop_span_y);
        layout = l;
        layouts_applied++;
    endtask

    // Every request yields exactly one result, so the unit is idle once all are in.
    task automatic settle();
        wait (results_checked == items_issued);
        repeat (4) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------- driver

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_valid && !o_stall)
                expected_covers.push_back(map_block_to_display(offered_block, layout));
            if (!(i_valid && o_stall)) begin
                if (send_gap > 0) begin
                    i_valid <= 1'b0;
                    send_gap--;
                end else if (pending_blocks.size() > 0) begin
                    offered_block = pending_blocks.pop_front();
                    i_valid        <= 1'b1;
                    i_block_left   <= offered_block.left;
                    i_block_right  <= offered_block.right;
                    i_block_top    <= offered_block.top;
                    i_block_bottom <= offered_block.bottom;
                    send_gap = idle_on ? $urandom_range(0, 3) : 0;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // --------------------------------------------------------------- monitor

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            recv_gap = 0;
            hold_left = 0;
        end else begin
            if (o_valid && !i_stall) begin
                seen_cover = t_cover'{o_status, o_dest_x, o_dest_y, o_dest_width,
                                      o_dest_height};
                if (expected_covers.size() == 0) begin
                    note_failure({"result with none pending: ", cover_text(seen_cover)});
                end else begin
                    want_cover = expected_covers.pop_front();
                    results_checked++;
                    case (want_cover.status)
                        cbdm_pkg::ST_VISIBLE: visible_seen++;
                        cbdm_pkg::ST_OUTSIDE: outside_seen++;
                        default:              invalid_seen++;
                    endcase
                    if (seen_cover !== want_cover)
                        note_failure($sformatf("request %0d expected %s, got %s",
                                               results_checked, cover_text(want_cover),
                                               cover_text(seen_cover)));
                end
                recv_gap = idle_on ? $urandom_range(0, 3) : 0;
            end
            if (holds_served != holds_requested) begin
                holds_served = holds_requested;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else if (recv_gap > 0) begin
                i_stall <= 1'b1;
                recv_gap--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // -------------------------------------------------------------- sequence

    initial begin
        t_layout bad_layouts[8] = '{
            t_layout'{16'd640, 16'd480, 3'd4, 16'd0, 16'd0, 16'd640, 16'd480},
            t_layout'{16'd640, 16'd480, 3'd7, 16'd0, 16'd0, 16'd640, 16'd480},
            t_layout'{16'd0, 16'd480, 3'd1, 16'd0, 16'd0, 16'd1, 16'd480},
            t_layout'{16'd640, 16'd0, 3'd1, 16'd0, 16'd0, 16'd640, 16'd1},
            t_layout'{16'd640, 16'd480, 3'd1, 16'd0, 16'd0, 16'd0, 16'd480},
            t_layout'{16'd640, 16'd480, 3'd1, 16'd0, 16'd0, 16'd640, 16'd0},
            t_layout'{16'd640, 16'd480, 3'd1, 16'd700, 16'd0, 16'd1, 16'd480},
            t_layout'{16'd640, 16'd480, 3'd1, 16'd10, 16'd0, 16'd640, 16'd480}
        };

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Registers still hold their reset values, so the layout is invalid.
        push_block(16'd0, 16'd10, 16'd0, 16'd10);
        settle();

        // Two-to-one downscale: only odd source columns and rows are sampled.
        set_layout(t_layout'{16'd640, 16'd480, 3'd1, 16'd0, 16'd0, 16'd640, 16'd480});
        push_block(16'd0, 16'd639, 16'd0, 16'd479);
        push_block(16'd0, 16'd0, 16'd0, 16'd0);
        push_block(16'd1, 16'd1, 16'd1, 16'd1);
        push_block(16'd639, 16'd639, 16'd479, 16'd479);
        push_block(16'd5, 16'd4, 16'd0, 16'd479);
        push_block(16'd0, 16'd639, 16'd9, 16'd8);
        push_block(16'd0, 16'd640, 16'd0, 16'd479);
        push_block(16'd0, 16'd639, 16'd0, 16'd480);
        push_block(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        settle();

        // Cropped window smaller than the display, so source pixels repeat.
        set_layout(t_layout'{16'd1000, 16'd800, 3'd2, 16'd100, 16'd50, 16'd300, 16'd200});
        push_block(16'd0, 16'd99, 16'd0, 16'd799);
        push_block(16'd100, 16'd100, 16'd50, 16'd50);
        settle();

        set_layout(t_layout'{16'hFFFF, 16'hFFFF, 3'd3, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF});
        push_block(16'd0, 16'hFFFE, 16'd0, 16'hFFFE);
        push_block(16'hFFFE, 16'hFFFE, 16'hFFFE, 16'hFFFE);
        push_block(16'd65000, 16'hFFFE, 16'd65000, 16'hFFFE);
        settle();

        // One-pixel window in the far corner covers the whole display.
        set_layout(t_layout'{16'hFFFF, 16'hFFFF, 3'd0, 16'hFFFE, 16'hFFFE, 16'd1, 16'd1});
        push_block(16'hFFFE, 16'hFFFE, 16'hFFFE, 16'hFFFE);
        settle();

        foreach (bad_layouts[i]) begin
            set_layout(bad_layouts[i]);
            push_block(16'd0, 16'd5, 16'd0, 16'd5);
            settle();
        end

        for (int round = 0; round < RANDOM_ROUNDS; round++) begin
            set_layout(random_layout(round % 5 == 3));
            @(posedge i_clk);
            idle_on <= (round % 4 != 1);
            // The sender keeps offering while the result side holds off.
            if (round == 5)
                holds_requested <= holds_requested + 1;
            @(posedge i_clk);
            queue_random_blocks(ROUND_ITEMS);
            settle();
        end

        repeat (SCAN_LATENCY + 20) @(posedge i_clk);
        if (expected_covers.size() != 0)
            note_failure($sformatf("%0d results never arrived", expected_covers.size()));
        $display("Mapped %0d block requests under %0d register layouts.",
                 results_checked, layouts_applied);
        $display("Outcomes: %0d visible, %0d outside the display, %0d invalid.",
                 visible_seen, outside_seen, invalid_seen);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches in total", fail_count);
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #(100_000_000);
        $display("Time limit reached with %0d of %0d results checked.",
                 results_checked, items_issued);
        $display("FAILURE");
        $finish;
    end

endmodule
